// ===== rtl/assert_macros.svh =====
// assertion macros for the top level rtl file of the price level book
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define PBU_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define PBU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pbu_pkg.sv =====
// shared types, constants and status codes of the price level book
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pbu_pkg;

    localparam int LEVELS  = 64;
    localparam int PRICE_W = 32;
    localparam int QTY_W   = 32;
    localparam int LVL_W   = $clog2(LEVELS);
    localparam int CNT_W   = $clog2(LEVELS + 1);

    typedef logic [PRICE_W-1:0] price_t;
    typedef logic [QTY_W-1:0]   qty_t;
    typedef logic [LVL_W-1:0]   lvl_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_UPDATED = 3'd1,
        ST_REMOVED = 3'd2,
        ST_FULL    = 3'd3,
        ST_IGNORED = 3'd4,
        ST_CLEARED = 3'd5
    } status_t;

    // per-cell update command, broadcast along a row
    typedef struct packed {
        logic ins;
        logic rem;
        logic upd;
    } cell_ctrl_t;

    // per-row command from the top level
    typedef struct packed {
        logic       clr;
        cell_ctrl_t cmd;
    } row_ctrl_t;

    // search result of one row
    typedef struct packed {
        logic hit;
        lvl_t pos;
        cnt_t count;
    } row_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pbu_cell.sv =====
// one price level cell: holds a price and quantity, compares and shifts
// depends on pbu_pkg
`timescale 1ns / 1ps
`default_nettype none

module pbu_cell (
    input  wire logic               aclk,
    input  wire logic               desc,
    input  wire logic               valid,
    input  wire pbu_pkg::price_t    cmp_price,
    input  wire logic               flag_load,
    input  wire pbu_pkg::cell_ctrl_t ctrl,
    input  wire pbu_pkg::price_t    new_price,
    input  wire pbu_pkg::qty_t      new_qty,
    input  wire logic               left_before,
    input  wire pbu_pkg::price_t    left_price,
    input  wire pbu_pkg::qty_t      left_qty,
    input  wire pbu_pkg::price_t    right_price,
    input  wire pbu_pkg::qty_t      right_qty,
    output pbu_pkg::price_t         price,
    output pbu_pkg::qty_t           qty,
    output logic                    ahead,
    output logic                    match,
    output pbu_pkg::price_t         price_next,
    output pbu_pkg::qty_t           qty_next
);
    import pbu_pkg::*;

    price_t price_reg;
    qty_t   qty_reg;
    logic   before_reg;
    logic   match_reg;
    logic   before_next;
    logic   match_next;

    // compare against the incoming price: strictly ahead of it, or equal
    always_comb begin
        match_next  = valid && (price_reg == cmp_price);
        before_next = valid && (desc ? (price_reg > cmp_price) : (price_reg < cmp_price));
    end

    // insert takes the new level or the left neighbor, remove takes the right, update takes the new quantity
    always_comb begin
        price_next = price_reg;
        qty_next   = qty_reg;
        priority if (ctrl.ins && !before_reg) begin
            if (left_before) begin
                price_next = new_price;
                qty_next   = new_qty;
            end else begin
                price_next = left_price;
                qty_next   = left_qty;
            end
        end else if (ctrl.rem && !before_reg) begin
            price_next = right_price;
            qty_next   = right_qty;
        end else if (ctrl.upd && match_reg) begin
            qty_next = new_qty;
        end else begin
            price_next = price_reg;
            qty_next   = qty_reg;
        end
    end

    // level storage and search flags
    always_ff @(posedge aclk) begin
        price_reg <= price_next;
        qty_reg   <= qty_next;
        if (flag_load) begin
            before_reg <= before_next;
            match_reg  <= match_next;
        end
    end

    assign price = price_reg;
    assign qty   = qty_reg;
    assign ahead = before_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// ===== rtl/pbu_row.sv =====
// one side of the book: a row of level cells plus the level count
// depends on pbu_pkg and pbu_cell
`timescale 1ns / 1ps
`default_nettype none

module pbu_row (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               desc,
    input  wire pbu_pkg::price_t    cmp_price,
    input  wire logic               flag_load,
    input  wire pbu_pkg::row_ctrl_t ctrl,
    input  wire pbu_pkg::price_t    new_price,
    input  wire pbu_pkg::qty_t      new_qty,
    output pbu_pkg::row_stat_t      stat,
    output pbu_pkg::cnt_t           count_next,
    output pbu_pkg::price_t         head_price,
    output pbu_pkg::qty_t           head_qty
);
    import pbu_pkg::*;

    cnt_t   count_reg;
    price_t cell_price [LEVELS];
    qty_t   cell_qty [LEVELS];
    price_t cell_price_nx [LEVELS];
    qty_t   cell_qty_nx [LEVELS];
    logic   cell_before [LEVELS];
    logic   cell_match [LEVELS];

    // the row of cells, each wired to its neighbors
    for (genvar i = 0; i < LEVELS; i++) begin : g_cell
        logic   l_before;
        price_t l_price;
        qty_t   l_qty;
        price_t r_price;
        qty_t   r_qty;

        if (i == 0) begin : g_first
            assign l_before = 1'b1;
            assign l_price  = new_price;
            assign l_qty    = new_qty;
        end else begin : g_inner
            assign l_before = cell_before[i-1];
            assign l_price  = cell_price[i-1];
            assign l_qty    = cell_qty[i-1];
        end

        if (i == LEVELS - 1) begin : g_last
            assign r_price = cell_price[i];
            assign r_qty   = cell_qty[i];
        end else begin : g_body
            assign r_price = cell_price[i+1];
            assign r_qty   = cell_qty[i+1];
        end

        pbu_cell u_cell (
            .aclk        (aclk),
            .desc        (desc),
            .valid       (CNT_W'(i) < count_reg),
            .cmp_price   (cmp_price),
            .flag_load   (flag_load),
            .ctrl        (ctrl.cmd),
            .new_price   (new_price),
            .new_qty     (new_qty),
            .left_before (l_before),
            .left_price  (l_price),
            .left_qty    (l_qty),
            .right_price (r_price),
            .right_qty   (r_qty),
            .price       (cell_price[i]),
            .qty         (cell_qty[i]),
            .ahead       (cell_before[i]),
            .match       (cell_match[i]),
            .price_next  (cell_price_nx[i]),
            .qty_next    (cell_qty_nx[i])
        );
    end

    // match flag and position of the first cell not ahead of the price
    always_comb begin
        logic prev;
        stat.hit = 1'b0;
        stat.pos = '0;
        prev     = 1'b1;
        for (int i = 0; i < LEVELS; i++) begin
            stat.hit = stat.hit | cell_match[i];
            if (prev && !cell_before[i]) begin
                stat.pos = stat.pos | LVL_W'(i);
            end
            prev = cell_before[i];
        end
        stat.count = count_reg;
    end

    // level count
    always_comb begin
        count_next = count_reg;
        priority if (ctrl.clr) begin
            count_next = '0;
        end else if (ctrl.cmd.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.cmd.rem) begin
            count_next = count_reg - CNT_W'(1);
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign head_price = cell_price_nx[0];
    assign head_qty   = cell_qty_nx[0];

endmodule

`default_nettype wire

// ===== rtl/price_level_book_update.sv =====
// price level book update: bid and ask rows of compare-and-shift cells
// the cell rows compare the input transaction as it is accepted; the shift and the result
// register follow in the update state, held while the output slot is full; no new item until then
// reset: synchronous active-low aresetn empties both sides and the output slot;
// level storage itself is not cleared
// depends on pbu_pkg, pbu_row, pbu_cell and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

module price_level_book_update (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // price[31:0], quantity[63:32]
    input  wire logic [1:0]   s_tuser,   // op[0], side[1]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [151:0]      m_tdata,   // level_index[5:0], bid_levels[12:6],
                                         // ask_levels[19:13], best_bid_price[51:20],
                                         // best_bid_qty[83:52], best_ask_price[115:84],
                                         // best_ask_qty[147:116], zero pad[151:148]
    output logic [2:0]        m_tuser    // status[2:0]
);
    import pbu_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } state_t;

    state_t    state_reg, state_next;
    logic      op_reg, side_reg;
    price_t    price_reg;
    qty_t      qty_reg;

    logic      accept;
    logic      out_free;
    logic      apply;

    row_ctrl_t bid_ctrl, ask_ctrl;
    row_stat_t bid_stat, ask_stat, sel_stat;
    cnt_t      bid_cnt_nx, ask_cnt_nx;
    price_t    bid_head_p, ask_head_p;
    qty_t      bid_head_q, ask_head_q;

    status_t   status;
    lvl_t      index;
    cell_ctrl_t act;

    logic      m_tvalid_reg;
    status_t   status_reg;
    lvl_t      index_reg;
    cnt_t      bid_cnt_reg, ask_cnt_reg;
    price_t    bbp_reg, bap_reg;
    qty_t      bbq_reg, baq_reg;

    // handshake
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign apply    = (state_reg == S_UPD) && out_free;

    // control state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_UPD;
            S_UPD:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= s_tuser[0];
            side_reg  <= s_tuser[1];
            price_reg <= s_tdata[31:0];
            qty_reg   <= s_tdata[63:32];
        end
    end

    // decide what the selected side does
    assign sel_stat = side_reg ? bid_stat : ask_stat;

    always_comb begin
        act    = '0;
        status = ST_IGNORED;
        index  = '0;
        priority if (op_reg) begin
            status = ST_CLEARED;
        end else if (sel_stat.hit && (qty_reg == '0)) begin
            act.rem = 1'b1;
            status  = ST_REMOVED;
            index   = sel_stat.pos;
        end else if (sel_stat.hit) begin
            act.upd = 1'b1;
            status  = ST_UPDATED;
            index   = sel_stat.pos;
        end else if (qty_reg == '0) begin
            status = ST_IGNORED;
        end else if (sel_stat.count == CNT_W'(LEVELS)) begin
            status = ST_FULL;
        end else begin
            act.ins = 1'b1;
            status  = ST_ADDED;
            index   = sel_stat.pos;
        end
    end

    // row commands, only in the cycle the update is applied
    always_comb begin
        bid_ctrl = '0;
        ask_ctrl = '0;
        if (apply) begin
            bid_ctrl.clr = op_reg;
            ask_ctrl.clr = op_reg;
            if (side_reg) begin
                bid_ctrl.cmd = act;
            end else begin
                ask_ctrl.cmd = act;
            end
        end
    end

    pbu_row u_bid (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc       (1'b1),
        .cmp_price  (s_tdata[31:0]),
        .flag_load  (accept),
        .ctrl       (bid_ctrl),
        .new_price  (price_reg),
        .new_qty    (qty_reg),
        .stat       (bid_stat),
        .count_next (bid_cnt_nx),
        .head_price (bid_head_p),
        .head_qty   (bid_head_q)
    );

    pbu_row u_ask (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc       (1'b0),
        .cmp_price  (s_tdata[31:0]),
        .flag_load  (accept),
        .ctrl       (ask_ctrl),
        .new_price  (price_reg),
        .new_qty    (qty_reg),
        .stat       (ask_stat),
        .count_next (ask_cnt_nx),
        .head_price (ask_head_p),
        .head_qty   (ask_head_q)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (apply) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (apply) begin
            status_reg  <= status;
            index_reg   <= index;
            bid_cnt_reg <= bid_cnt_nx;
            ask_cnt_reg <= ask_cnt_nx;
            bbp_reg     <= (bid_cnt_nx != '0) ? bid_head_p : '0;
            bbq_reg     <= (bid_cnt_nx != '0) ? bid_head_q : '0;
            bap_reg     <= (ask_cnt_nx != '0) ? ask_head_p : '0;
            baq_reg     <= (ask_cnt_nx != '0) ? ask_head_q : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {4'b0000, baq_reg, bap_reg, bbq_reg, bbp_reg,
                       ask_cnt_reg, bid_cnt_reg, index_reg};

    // checks
    `PBU_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, (bid_stat.count <= CNT_W'(LEVELS)) && (ask_stat.count <= CNT_W'(LEVELS)), "level count above table depth")
    `PBU_ASSERT_NEXT(a_accept_to_upd, aclk, aresetn, accept, (state_reg == S_UPD) && !s_tready, "accepted item did not enter update")
    `PBU_ASSERT_NEXT(a_apply_gives_result, aclk, aresetn, apply, m_tvalid && (state_reg == S_IDLE), "applied update produced no result")

endmodule

`default_nettype wire
